/* rtl/alh_pkg.sv */
`timescale 1ns / 1ps

package alh_pkg;

   // Field widths
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned LEVEL_W  = 2;
   localparam int unsigned PERIOD_W = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 12;

   // Operation codes
   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // Level codes; LEVEL_NONE marks "not yet initialized"
   localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MIDDLE = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_DARK   = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_PERIOD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT_BOTTOM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_TOP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_TOP      = 3'd4;

   // Register reset values
   localparam logic [PERIOD_W-1:0] INIT_PERIOD_RST   = 3'd4;
   localparam logic [SAMPLE_W-1:0] BRIGHT_BOTTOM_RST = 12'd2048;
   localparam logic [SAMPLE_W-1:0] MIDDLE_BOTTOM_RST = 12'd1024;
   localparam logic [SAMPLE_W-1:0] MIDDLE_TOP_RST    = 12'd2304;
   localparam logic [SAMPLE_W-1:0] DARK_TOP_RST      = 12'd1280;

   typedef struct packed {
      logic                op;
      logic [SAMPLE_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               from_startup;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic compare;
      logic commit;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic early_done;
      logic emit;
      logic out_busy;
   } ctl_status_type;

endpackage

/* rtl/alh_ctrl.sv */
`timescale 1ns / 1ps

module alh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  alh_pkg::ctl_status_type status,
   output alh_pkg::ctl_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_START  = 2'd1;
   localparam logic [1:0] S_CMP    = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   // Sequencer: accept, start-up check, compare, commit
   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.start   = 1'b0;
      cmd.compare = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = status.early_done ? S_IDLE : S_CMP;
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_COMMIT;
         end
         S_COMMIT: begin
            // hold while a report is due and the output slot is still occupied
            if (!(status.emit && status.out_busy)) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/alh_datapath.sv */
`timescale 1ns / 1ps

module alh_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  alh_pkg::ctl_cmd_type                 cmd,
   output alh_pkg::ctl_status_type              status,
   input  alh_pkg::req_payload_type             req_payload,
   input  logic                                 csr_write_en,
   input  logic [alh_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [alh_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output alh_pkg::rsp_payload_type             rsp_payload
);

   // Configuration
   logic [alh_pkg::PERIOD_W-1:0] init_period_ff;
   logic [alh_pkg::SAMPLE_W-1:0] bright_bottom_ff;
   logic [alh_pkg::SAMPLE_W-1:0] middle_bottom_ff;
   logic [alh_pkg::SAMPLE_W-1:0] middle_top_ff;
   logic [alh_pkg::SAMPLE_W-1:0] dark_top_ff;

   // Item holding
   logic                         op_ff;
   logic [alh_pkg::SAMPLE_W-1:0] sample_ff;

   // Level state
   logic [alh_pkg::LEVEL_W-1:0]  level_ff,         level_in;
   logic                         pending_ff,       pending_in;
   logic [alh_pkg::PERIOD_W-1:0] startup_count_ff, startup_count_in;
   logic [alh_pkg::PERIOD_W-1:0] oob_count_ff,     oob_count_in;

   // Per-item intermediates
   logic                         first_ff,    first_in;
   logic [alh_pkg::LEVEL_W-1:0]  next_ff,     next_in;
   logic [alh_pkg::PERIOD_W-1:0] oob_next_ff, oob_next_in;

   // Output slot
   logic                         rsp_valid_ff, rsp_valid_in;
   alh_pkg::rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic                         pend_eff;
   logic [alh_pkg::PERIOD_W-1:0] cnt_new;
   logic [alh_pkg::PERIOD_W:0]   cnt_plus;
   logic                         hold;
   logic                         low, high;
   logic [alh_pkg::LEVEL_W-1:0]  next_level;
   logic                         emit;

   // Start-up delay check
   assign pend_eff = pending_ff || (level_ff == alh_pkg::LEVEL_NONE);
   assign cnt_new  = (pending_ff ? startup_count_ff : '0) + 3'd1;
   assign cnt_plus = {1'b0, cnt_new} + 4'd1;
   assign hold     = (cnt_plus < {1'b0, init_period_ff});

   // Band check and neighbor search
   always_comb begin
      low  = 1'b0;
      high = 1'b0;
      case (level_ff)
         alh_pkg::LEVEL_BRIGHT: low = (sample_ff < bright_bottom_ff);
         alh_pkg::LEVEL_MIDDLE: begin
            low  = (sample_ff < middle_bottom_ff);
            high = (sample_ff > middle_top_ff);
         end
         default:               high = (sample_ff > dark_top_ff);
      endcase
      next_level = level_ff;
      if (low) begin
         if (level_ff == alh_pkg::LEVEL_BRIGHT) begin
            next_level = (sample_ff > middle_bottom_ff) ? alh_pkg::LEVEL_MIDDLE
                                                        : alh_pkg::LEVEL_DARK;
         end else begin
            next_level = alh_pkg::LEVEL_DARK;
         end
      end
      // brighter search wins when both limits are crossed
      if (high) begin
         if (level_ff == alh_pkg::LEVEL_DARK) begin
            next_level = (sample_ff < middle_top_ff) ? alh_pkg::LEVEL_MIDDLE
                                                     : alh_pkg::LEVEL_BRIGHT;
         end else begin
            next_level = alh_pkg::LEVEL_BRIGHT;
         end
      end
   end

   assign emit = first_ff || (oob_next_ff == init_period_ff);

   assign status.early_done = (op_ff == alh_pkg::OP_RESTART) || (pend_eff && hold);
   assign status.emit       = emit;
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   // State updates per step
   always_comb begin
      level_in         = level_ff;
      pending_in       = pending_ff;
      startup_count_in = startup_count_ff;
      oob_count_in     = oob_count_ff;
      first_in         = first_ff;
      next_in          = next_ff;
      oob_next_in      = oob_next_ff;
      rsp_payload_in   = rsp_payload_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (cmd.start) begin
         first_in = 1'b0;
         if (op_ff == alh_pkg::OP_RESTART) begin
            level_in   = alh_pkg::LEVEL_NONE;
            pending_in = 1'b0;
         end else if (pend_eff) begin
            startup_count_in = cnt_new;
            if (hold) begin
               pending_in = 1'b1;
            end else begin
               pending_in = 1'b0;
               first_in   = 1'b1;
               level_in   = alh_pkg::LEVEL_BRIGHT;
            end
         end
      end

      if (cmd.compare) begin
         next_in     = next_level;
         oob_next_in = (low || high) ? oob_count_ff + 3'd1 : '0;
      end

      if (cmd.commit) begin
         if (emit) begin
            oob_count_in                = '0;
            level_in                    = next_ff;
            rsp_valid_in                = 1'b1;
            rsp_payload_in.level        = next_ff;
            rsp_payload_in.from_startup = first_ff;
         end else begin
            oob_count_in = oob_next_ff;
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         init_period_ff   <= alh_pkg::INIT_PERIOD_RST;
         bright_bottom_ff <= alh_pkg::BRIGHT_BOTTOM_RST;
         middle_bottom_ff <= alh_pkg::MIDDLE_BOTTOM_RST;
         middle_top_ff    <= alh_pkg::MIDDLE_TOP_RST;
         dark_top_ff      <= alh_pkg::DARK_TOP_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            alh_pkg::CSR_INIT_PERIOD:   init_period_ff   <= csr_wdata[alh_pkg::PERIOD_W-1:0];
            alh_pkg::CSR_BRIGHT_BOTTOM: bright_bottom_ff <= csr_wdata;
            alh_pkg::CSR_MIDDLE_BOTTOM: middle_bottom_ff <= csr_wdata;
            alh_pkg::CSR_MIDDLE_TOP:    middle_top_ff    <= csr_wdata;
            alh_pkg::CSR_DARK_TOP:      dark_top_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff         <= alh_pkg::LEVEL_NONE;
         pending_ff       <= 1'b0;
         startup_count_ff <= '0;
         oob_count_ff     <= '0;
         first_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         level_ff         <= level_in;
         pending_ff       <= pending_in;
         startup_count_ff <= startup_count_in;
         oob_count_ff     <= oob_count_in;
         first_ff         <= first_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_payload.op;
         sample_ff <= req_payload.sample;
      end
      next_ff        <= next_in;
      oob_next_ff    <= oob_next_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* rtl/ambient_light_level_hysteresis_core.sv */
`timescale 1ns / 1ps
// Each result passes the start-up check, compare and commit steps after its item's transfer;
//   commit is held only while the previous result still waits in the output slot.
// A new item is taken only once the previous one is through; restarts and swallowed start-up
//   samples end after the start-up check. The single controller sequences one item at a time.
// Reset (synchronous, active high) restores register defaults and the uninitialized level.
module ambient_light_level_hysteresis_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  alh_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output alh_pkg::rsp_payload_type       rsp_payload,
   input  logic                           csr_write_en,
   input  logic [alh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [alh_pkg::CSR_DATA_W-1:0] csr_wdata
);

   alh_pkg::ctl_cmd_type    cmd;
   alh_pkg::ctl_status_type status;

   alh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   alh_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   // A transfer in always starts a multi-cycle item
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken on consecutive cycles");

   // A new result is only loaded from the commit step
   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared outside of an item");

   // Reported level is always a real level
   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.level != alh_pkg::LEVEL_NONE))
      else $error("uninitialized level reported");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

// Tracks the level state from every accepted transfer and holds the reports it predicts
class hysteresis_tracker;
   logic [alh_pkg::PERIOD_W-1:0] period;
   logic [alh_pkg::SAMPLE_W-1:0] bright_bottom;
   logic [alh_pkg::SAMPLE_W-1:0] middle_bottom;
   logic [alh_pkg::SAMPLE_W-1:0] middle_top;
   logic [alh_pkg::SAMPLE_W-1:0] dark_top;
   logic [alh_pkg::LEVEL_W-1:0]  level_now;
   logic                         starting;
   logic [2:0]                   start_count;
   logic [2:0]                   miss_count;
   alh_pkg::rsp_payload_type     expected_reports[$];
   int                           errors;

   function new();
      period        = alh_pkg::INIT_PERIOD_RST;
      bright_bottom = alh_pkg::BRIGHT_BOTTOM_RST;
      middle_bottom = alh_pkg::MIDDLE_BOTTOM_RST;
      middle_top    = alh_pkg::MIDDLE_TOP_RST;
      dark_top      = alh_pkg::DARK_TOP_RST;
      level_now     = alh_pkg::LEVEL_NONE;
      starting      = 1'b0;
      start_count   = '0;
      miss_count    = '0;
      errors        = 0;
   endfunction

   function void write_reg(logic [alh_pkg::CSR_IDX_W-1:0] idx,
                           logic [alh_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         alh_pkg::CSR_INIT_PERIOD:   period        = data[alh_pkg::PERIOD_W-1:0];
         alh_pkg::CSR_BRIGHT_BOTTOM: bright_bottom = data;
         alh_pkg::CSR_MIDDLE_BOTTOM: middle_bottom = data;
         alh_pkg::CSR_MIDDLE_TOP:    middle_top    = data;
         alh_pkg::CSR_DARK_TOP:      dark_top      = data;
         default: ;
      endcase
   endfunction

   // Advance the level state by one input transfer; queue a report if one is due
   function void predict_report(alh_pkg::req_payload_type req);
      logic [alh_pkg::SAMPLE_W-1:0] s;
      logic [alh_pkg::LEVEL_W-1:0]  nxt;
      logic                         first;
      logic                         low;
      logic                         high;
      int                           count_i;
      int                           period_i;
      alh_pkg::rsp_payload_type     rpt;
      first = 1'b0;
      low   = 1'b0;
      high  = 1'b0;
      if (req.op == alh_pkg::OP_RESTART) begin
         level_now = alh_pkg::LEVEL_NONE;
         starting  = 1'b0;
         return;
      end
      s = req.sample;
      if (level_now == alh_pkg::LEVEL_NONE && !starting) begin
         starting    = 1'b1;
         start_count = '0;
      end
      // start-up delay: swallow samples until the count reaches period-1
      if (starting) begin
         start_count = start_count + 3'd1;
         count_i  = int'(start_count);
         period_i = int'(period);
         if (count_i < period_i - 1) return;
         starting  = 1'b0;
         first     = 1'b1;
         level_now = alh_pkg::LEVEL_BRIGHT;
      end
      case (level_now)
         alh_pkg::LEVEL_BRIGHT: low = s < bright_bottom;
         alh_pkg::LEVEL_MIDDLE: begin
            low  = s < middle_bottom;
            high = s > middle_top;
         end
         default: high = s > dark_top;
      endcase
      // neighbor search; brighter result wins when both limits are crossed
      nxt = level_now;
      if (low) begin
         if (level_now == alh_pkg::LEVEL_BRIGHT)
            nxt = (s > middle_bottom) ? alh_pkg::LEVEL_MIDDLE : alh_pkg::LEVEL_DARK;
         else
            nxt = alh_pkg::LEVEL_DARK;
      end
      if (high) begin
         if (level_now == alh_pkg::LEVEL_DARK)
            nxt = (s < middle_top) ? alh_pkg::LEVEL_MIDDLE : alh_pkg::LEVEL_BRIGHT;
         else
            nxt = alh_pkg::LEVEL_BRIGHT;
      end
      if (low || high) miss_count = miss_count + 3'd1;
      else miss_count = '0;
      if (first || miss_count == period) begin
         miss_count        = '0;
         level_now         = nxt;
         rpt.level         = nxt;
         rpt.from_startup  = first;
         expected_reports.push_back(rpt);
      end
   endfunction

   function void check_report(alh_pkg::rsp_payload_type got);
      alh_pkg::rsp_payload_type want;
      if (expected_reports.size() == 0) begin
         $display("%0t: unexpected report, expected none, actual level %0d from_startup %0d",
                  $time, got.level, got.from_startup);
         errors++;
         return;
      end
      want = expected_reports.pop_front();
      if (got.level !== want.level) begin
         $display("%0t: level mismatch, expected %0d, actual %0d",
                  $time, want.level, got.level);
         errors++;
      end
      if (got.from_startup !== want.from_startup) begin
         $display("%0t: from_startup mismatch, expected %0d, actual %0d",
                  $time, want.from_startup, got.from_startup);
         errors++;
      end
   endfunction

   function int pending();
      return expected_reports.size();
   endfunction
endclass

module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 55;
   localparam int RESTART_MARK   = -1;
   localparam int DIRECTED_N     = 25;
   // start-up, move darker, move middle, move brighter, restarts in start-up
   localparam int DIRECTED [DIRECTED_N] = '{
      100, 200, 4095, 0, 0, 0, 0, 2000, 500, 2000, 2000, 2000, 2000,
      3000, 3000, 3000, 3000, 1500, 1500, RESTART_MARK, 7, RESTART_MARK,
      2048, 2048, 2047};

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   alh_pkg::req_payload_type       req_payload;
   logic                           rsp_valid;
   logic                           rsp_stall;
   alh_pkg::rsp_payload_type       rsp_payload;
   logic                           csr_write_en;
   logic [alh_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [alh_pkg::CSR_DATA_W-1:0] csr_wdata;

   hysteresis_tracker tracker;
   bit                send_quiet;
   bit                recv_quiet;
   int                hold_requests;
   int                recv_left;
   int                idle_cycles;

   ambient_light_level_hysteresis_core uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_valid && !req_stall) tracker.predict_report(req_payload);
         if (rsp_valid && !rsp_stall) tracker.check_report(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d reports outstanding",
                     $time, tracker.pending());
            $display("tb: errors");
            $finish;
         end
      end
   end

   // Receiver: random stall per report, quiet stretches, one long hold on request
   initial begin : receiver
      int n;
      int holds_done;
      rsp_stall <= 1'b0;
      recv_left  = 0;
      recv_quiet = 1'b0;
      holds_done = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_requests > holds_done) begin
            holds_done++;
            n = LONG_HOLD;
         end else begin
            if (recv_left == 0) begin
               recv_quiet = ($urandom_range(0, 3) == 0);
               recv_left  = $urandom_range(10, 30);
            end
            recv_left--;
            n = recv_quiet ? 0 : $urandom_range(0, 19);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // One input transfer; valid stays high into the next item when no gap is drawn
   task automatic send_item(input logic op, input logic [alh_pkg::SAMPLE_W-1:0] smp);
      int                       gap;
      alh_pkg::req_payload_type item;
      gap = send_quiet ? 0 : $urandom_range(0, 19);
      item.op     = op;
      item.sample = smp;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and let every pending report and in-flight item drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [alh_pkg::CSR_IDX_W-1:0] idx,
                            input logic [alh_pkg::CSR_DATA_W-1:0] data);
      csr_index    <= idx;
      csr_wdata    <= data;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tracker.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic set_config(input logic [alh_pkg::PERIOD_W-1:0] per,
                             input logic [alh_pkg::SAMPLE_W-1:0] bb,
                             input logic [alh_pkg::SAMPLE_W-1:0] mb,
                             input logic [alh_pkg::SAMPLE_W-1:0] mt,
                             input logic [alh_pkg::SAMPLE_W-1:0] dt);
      logic [alh_pkg::CSR_DATA_W-1:0] per_word;
      // upper bits of the period word are don't-care
      per_word = alh_pkg::CSR_DATA_W'($urandom());
      per_word[alh_pkg::PERIOD_W-1:0] = per;
      write_reg(alh_pkg::CSR_INIT_PERIOD, per_word);
      write_reg(alh_pkg::CSR_BRIGHT_BOTTOM, bb);
      write_reg(alh_pkg::CSR_MIDDLE_BOTTOM, mb);
      write_reg(alh_pkg::CSR_MIDDLE_TOP, mt);
      write_reg(alh_pkg::CSR_DARK_TOP, dt);
   endtask

   // Samples cluster around the active limits so the searches and counters get exercised
   function automatic logic [alh_pkg::SAMPLE_W-1:0] pick_sample();
      int kind;
      int base;
      int offset;
      int v;
      kind = $urandom_range(0, 9);
      if (kind < 2) return alh_pkg::SAMPLE_W'($urandom());
      if (kind == 2) return ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
      case ($urandom_range(0, 3))
         0: base = int'(tracker.bright_bottom);
         1: base = int'(tracker.middle_bottom);
         2: base = int'(tracker.middle_top);
         default: base = int'(tracker.dark_top);
      endcase
      offset = $urandom_range(0, 4);
      v = base + offset - 2;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[alh_pkg::SAMPLE_W-1:0];
   endfunction

   // Runs of similar samples with some noise and the occasional restart
   task automatic run_phase(input int n_items);
      int                           sent;
      int                           run_len;
      logic [alh_pkg::SAMPLE_W-1:0] base;
      logic [alh_pkg::SAMPLE_W-1:0] smp;
      sent = 0;
      while (sent < n_items) begin
         send_quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 24) == 0) begin
            send_item(alh_pkg::OP_RESTART, alh_pkg::SAMPLE_W'($urandom()));
            sent++;
         end else begin
            run_len = $urandom_range(1, 9);
            base    = pick_sample();
            repeat (run_len) begin
               smp = ($urandom_range(0, 5) == 0) ? pick_sample() : base;
               send_item(alh_pkg::OP_SAMPLE, smp);
               sent++;
            end
         end
      end
   endtask

   initial begin : sender
      tracker = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= alh_pkg::CSR_INIT_PERIOD;
      csr_wdata    <= '0;
      hold_requests = 0;
      send_quiet    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed pass on reset settings
      for (int i = 0; i < DIRECTED_N; i++) begin
         if (DIRECTED[i] == RESTART_MARK) send_item(alh_pkg::OP_RESTART, 12'hFFF);
         else send_item(alh_pkg::OP_SAMPLE, DIRECTED[i][alh_pkg::SAMPLE_W-1:0]);
      end
      wait_idle();

      // period zero reports in-band samples at once; hold the output to back up the input
      set_config(3'd0, alh_pkg::BRIGHT_BOTTOM_RST, alh_pkg::MIDDLE_BOTTOM_RST,
                 alh_pkg::MIDDLE_TOP_RST, alh_pkg::DARK_TOP_RST);
      hold_requests++;
      run_phase(PHASE_ITEMS);
      wait_idle();

      set_config(3'd1, 12'd3000, 12'd1000, 12'd3500, 12'd500);
      run_phase(PHASE_ITEMS);
      wait_idle();

      // extreme limits: nothing is ever out of band
      set_config(3'd7, 12'd0, 12'd0, 12'd4095, 12'd4095);
      run_phase(PHASE_ITEMS);
      wait_idle();

      // crossed middle limits and the opposite extremes
      set_config(3'd2, 12'd4095, 12'd3000, 12'd1000, 12'd0);
      run_phase(PHASE_ITEMS);
      wait_idle();

      repeat (7) begin
         set_config(alh_pkg::PERIOD_W'($urandom_range(0, 7)),
                    alh_pkg::SAMPLE_W'($urandom()), alh_pkg::SAMPLE_W'($urandom()),
                    alh_pkg::SAMPLE_W'($urandom()), alh_pkg::SAMPLE_W'($urandom()));
         run_phase(PHASE_ITEMS);
         wait_idle();
      end

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
